>>> rtl/cftp_pkg.sv
// Shared types, constants and scale tables for the command frame text parser.
// No dependencies; every other RTL file refers to this package by scoped names.
`default_nettype none

package cftp_pkg;

    localparam int FRAME_LEN     = 48;
    localparam int DIGITS_NEEDED = 34;
    localparam int POINTS_NEEDED = 5;

    localparam int POS_W   = 6;
    localparam int CNT_W   = 6;
    localparam int MANT_W  = 27;
    localparam int FRAC_W  = 4;
    localparam int SCALE_W = 24;
    localparam int VAL_W   = 50;
    localparam int MARK_N  = 9;

    // marker positions inside the frame
    localparam logic [POS_W-1:0] POS_HEAD = 6'd0;
    localparam logic [POS_W-1:0] POS_V    = 6'd1;
    localparam logic [POS_W-1:0] POS_A    = 6'd9;
    localparam logic [POS_W-1:0] POS_ANG  = 6'd10;
    localparam logic [POS_W-1:0] POS_SEMI = 6'd19;
    localparam logic [POS_W-1:0] POS_P    = 6'd20;
    localparam logic [POS_W-1:0] POS_I    = 6'd29;
    localparam logic [POS_W-1:0] POS_D    = 6'd38;
    localparam logic [POS_W-1:0] POS_BANG = 6'd47;

    localparam logic [MANT_W-1:0] MANT_MAX   = 27'd99999999;
    localparam logic [MANT_W-1:0] MANT_TENTH = 27'd9999999;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_V      = 8'h56;

    typedef enum logic [1:0] {
        ST_GOOD,
        ST_LENGTH,
        ST_PLACE,
        ST_INCOMPLETE
    } t_status;

    typedef enum logic [1:0] {
        INFO_NONE,
        INFO_MOTOR,
        INFO_FEEDBACK
    } t_info;

    typedef enum logic [1:0] {
        ANG_NONE,
        ANG_DEG,
        ANG_RAD
    } t_angle;

    typedef enum logic [2:0] {
        FLD_VOLT,
        FLD_ANGLE,
        FLD_KP,
        FLD_KI,
        FLD_KD
    } t_field;

    // snapshot handed from the scanner to the conversion/result stage
    typedef struct packed {
        logic              valid;
        logic              cap;     // a field was closed by this character
        t_field            sel;
        logic [MANT_W-1:0] m;       // mantissa of the closed field
        logic [MANT_W-1:0] q;       // mantissa scaled down, used when k > 7
        logic [FRAC_W-1:0] k;       // fraction digit count
        logic              eom;     // frame end: carries the result header
        t_status           status;
        t_info             info;
        t_angle            angle;
    } t_snap;

    // 10^(7-k) for k in 0..7
    function automatic logic [SCALE_W-1:0] scale_of(input logic [FRAC_W-1:0] k);
        case (k)
            4'd0:    return 24'd10000000;
            4'd1:    return 24'd1000000;
            4'd2:    return 24'd100000;
            4'd3:    return 24'd10000;
            4'd4:    return 24'd1000;
            4'd5:    return 24'd100;
            4'd6:    return 24'd10;
            4'd7:    return 24'd1;
            default: return 24'd0;
        endcase
    endfunction

    // saturated mantissa divided by 10^(k-7), for k in 8..14
    function automatic logic [MANT_W-1:0] sat_quot(input logic [FRAC_W-1:0] k);
        case (k)
            4'd8:    return 27'd9999999;
            4'd9:    return 27'd999999;
            4'd10:   return 27'd99999;
            4'd11:   return 27'd9999;
            4'd12:   return 27'd999;
            4'd13:   return 27'd99;
            4'd14:   return 27'd9;
            default: return 27'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> rtl/cftp_ifs.sv
// Valid/ready channel interfaces: characters in, parsed frame results out.
// Depends on cftp_pkg for field widths and codes.
`default_nettype none

interface cftp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_message;

    modport source (output valid, output symbol, output end_of_message, input ready);
    modport sink   (input valid, input symbol, input end_of_message, output ready);
endinterface

interface cftp_out_if;
    logic                         valid;
    logic                         ready;
    cftp_pkg::t_status            status;
    cftp_pkg::t_info              info_type;
    cftp_pkg::t_angle             angle_type;
    logic [cftp_pkg::VAL_W-1:0]   voltage;
    logic [cftp_pkg::VAL_W-1:0]   angle;
    logic [cftp_pkg::VAL_W-1:0]   kp;
    logic [cftp_pkg::VAL_W-1:0]   ki;
    logic [cftp_pkg::VAL_W-1:0]   kd;

    modport source (output valid, output status, output info_type, output angle_type,
                    output voltage, output angle, output kp, output ki, output kd,
                    input ready);
    modport sink   (input valid, input status, input info_type, input angle_type,
                    input voltage, input angle, input kp, input ki, input kd,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/cftp_scan.sv
// Character scanner: position check, marker decode, digit accumulation, counts.
// Depends on cftp_pkg; emits a registered t_snap per closed field or frame end.
`default_nettype none

module cftp_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic            i_load,
    input  logic [7:0]      i_symbol,
    input  logic            i_eom,
    output cftp_pkg::t_snap o_snap
);

    logic [cftp_pkg::POS_W-1:0]  r_pos,    n_pos;
    logic [cftp_pkg::MARK_N-1:0] r_found,  n_found;
    logic                        r_oop,    n_oop;
    logic [cftp_pkg::CNT_W-1:0]  r_digits, n_digits;
    logic [cftp_pkg::CNT_W-1:0]  r_points, n_points;
    logic [cftp_pkg::MANT_W-1:0] r_m,      n_m;
    logic [cftp_pkg::MANT_W-1:0] r_q,      n_q;
    logic [cftp_pkg::FRAC_W-1:0] r_k,      n_k;
    logic                        r_infrac, n_infrac;
    cftp_pkg::t_info             r_info,   n_info;
    cftp_pkg::t_angle            r_angle,  n_angle;
    cftp_pkg::t_snap             r_snap,   n_snap;

    logic                        mark_hit;
    logic                        mark_cap;
    logic [cftp_pkg::MARK_N-1:0] mark_mask;
    cftp_pkg::t_field            mark_sel;
    cftp_pkg::t_info             hit_info;
    cftp_pkg::t_angle            hit_angle;
    logic                        is_digit;
    logic                        is_point;
    logic [cftp_pkg::MANT_W+3:0] m_wide;
    logic [cftp_pkg::MANT_W-1:0] m_step;
    logic [cftp_pkg::MANT_W-1:0] q_step;
    logic [cftp_pkg::FRAC_W-1:0] k_step;

    assign is_digit = (i_symbol >= cftp_pkg::CH_ZERO) && (i_symbol <= cftp_pkg::CH_NINE);
    assign is_point = (i_symbol == cftp_pkg::CH_POINT);

    // marker expected at the current position
    always_comb begin
        mark_hit  = 1'b0;
        mark_cap  = 1'b0;
        mark_mask = '0;
        mark_sel  = cftp_pkg::FLD_VOLT;
        hit_info  = r_info;
        hit_angle = r_angle;
        case (r_pos)
            cftp_pkg::POS_HEAD: begin
                mark_mask = 9'b000000001;
                if (i_symbol == cftp_pkg::CH_DOLLAR) begin
                    mark_hit = 1'b1;
                    hit_info = cftp_pkg::INFO_MOTOR;
                end else if (i_symbol == cftp_pkg::CH_HASH) begin
                    mark_hit = 1'b1;
                    hit_info = cftp_pkg::INFO_FEEDBACK;
                end
            end
            cftp_pkg::POS_V: begin
                mark_mask = 9'b000000010;
                mark_hit  = (i_symbol == cftp_pkg::CH_V);
            end
            cftp_pkg::POS_A: begin
                mark_mask = 9'b000000100;
                mark_hit  = (i_symbol == cftp_pkg::CH_A);
                mark_cap  = 1'b1;
                mark_sel  = cftp_pkg::FLD_VOLT;
            end
            cftp_pkg::POS_ANG: begin
                mark_mask = 9'b000001000;
                if (i_symbol == cftp_pkg::CH_D) begin
                    mark_hit  = 1'b1;
                    hit_angle = cftp_pkg::ANG_DEG;
                end else if (i_symbol == cftp_pkg::CH_R) begin
                    mark_hit  = 1'b1;
                    hit_angle = cftp_pkg::ANG_RAD;
                end
            end
            cftp_pkg::POS_SEMI: begin
                mark_mask = 9'b000010000;
                mark_hit  = (i_symbol == cftp_pkg::CH_SEMI);
                mark_cap  = 1'b1;
                mark_sel  = cftp_pkg::FLD_ANGLE;
            end
            cftp_pkg::POS_P: begin
                mark_mask = 9'b000100000;
                mark_hit  = (i_symbol == cftp_pkg::CH_P);
            end
            cftp_pkg::POS_I: begin
                mark_mask = 9'b001000000;
                mark_hit  = (i_symbol == cftp_pkg::CH_I);
                mark_cap  = 1'b1;
                mark_sel  = cftp_pkg::FLD_KP;
            end
            cftp_pkg::POS_D: begin
                mark_mask = 9'b010000000;
                mark_hit  = (i_symbol == cftp_pkg::CH_D);
                mark_cap  = 1'b1;
                mark_sel  = cftp_pkg::FLD_KI;
            end
            cftp_pkg::POS_BANG: begin
                mark_mask = 9'b100000000;
                mark_hit  = (i_symbol == cftp_pkg::CH_BANG);
                mark_cap  = 1'b1;
                mark_sel  = cftp_pkg::FLD_KD;
            end
            default: begin
                mark_hit = 1'b0;
            end
        endcase
    end

    // digit shift-add with saturation; q tracks m / 10^(k-7) without a divider:
    // it equals m while k <= 7, holds when a fraction digit is appended, and
    // takes a table value once the mantissa saturates, and is zero once k reaches 15
    always_comb begin
        m_wide = ({4'b0, r_m} << 3) + ({4'b0, r_m} << 1) + {27'b0, i_symbol[3:0]};
        if (r_m > cftp_pkg::MANT_TENTH || m_wide > {4'b0, cftp_pkg::MANT_MAX}) begin
            m_step = cftp_pkg::MANT_MAX;
        end else begin
            m_step = m_wide[cftp_pkg::MANT_W-1:0];
        end
        if (r_infrac && r_k != 4'hF) begin
            k_step = r_k + 4'd1;
        end else begin
            k_step = r_k;
        end
        if (k_step <= 4'd7) begin
            q_step = m_step;
        end else if (k_step == 4'hF) begin
            q_step = '0;
        end else if (m_step == cftp_pkg::MANT_MAX) begin
            q_step = cftp_pkg::sat_quot(k_step);
        end else begin
            q_step = r_q;
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_found  = r_found;
        n_oop    = r_oop;
        n_digits = r_digits;
        n_points = r_points;
        n_m      = r_m;
        n_q      = r_q;
        n_k      = r_k;
        n_infrac = r_infrac;
        n_info   = r_info;
        n_angle  = r_angle;

        n_snap        = '0;
        n_snap.sel    = cftp_pkg::FLD_VOLT;
        n_snap.status = cftp_pkg::ST_GOOD;
        n_snap.info   = cftp_pkg::INFO_NONE;
        n_snap.angle  = cftp_pkg::ANG_NONE;

        if (i_take) begin
            if (r_pos < 6'(cftp_pkg::FRAME_LEN) && !r_oop) begin
                if (mark_hit) begin
                    n_found = r_found | mark_mask;
                    n_info  = hit_info;
                    n_angle = hit_angle;
                    if (mark_cap) begin
                        n_snap.cap = 1'b1;
                        n_snap.sel = mark_sel;
                        n_snap.m   = r_m;
                        n_snap.q   = r_q;
                        n_snap.k   = r_k;
                        n_m        = '0;
                        n_q        = '0;
                        n_k        = '0;
                        n_infrac   = 1'b0;
                    end
                end else if (is_digit) begin
                    n_m = m_step;
                    n_q = q_step;
                    n_k = k_step;
                    if (r_digits != '1) begin
                        n_digits = r_digits + 6'd1;
                    end
                end else if (is_point) begin
                    n_infrac = 1'b1;
                    if (r_points != '1) begin
                        n_points = r_points + 6'd1;
                    end
                end else begin
                    n_oop = 1'b1;
                end
            end
            if (r_pos != '1) begin
                n_pos = r_pos + 6'd1;
            end

            if (i_eom) begin
                n_snap.eom   = 1'b1;
                n_snap.info  = n_info;
                n_snap.angle = n_angle;
                if (r_pos != cftp_pkg::POS_BANG) begin
                    n_snap.status = cftp_pkg::ST_LENGTH;
                end else if (n_oop) begin
                    n_snap.status = cftp_pkg::ST_PLACE;
                end else if (n_digits == 6'(cftp_pkg::DIGITS_NEEDED) &&
                             n_points == 6'(cftp_pkg::POINTS_NEEDED) && (&n_found)) begin
                    n_snap.status = cftp_pkg::ST_GOOD;
                end else begin
                    n_snap.status = cftp_pkg::ST_INCOMPLETE;
                end
                // new frame starts from scratch
                n_pos    = '0;
                n_found  = '0;
                n_oop    = 1'b0;
                n_digits = '0;
                n_points = '0;
                n_m      = '0;
                n_q      = '0;
                n_k      = '0;
                n_infrac = 1'b0;
                n_info   = cftp_pkg::INFO_NONE;
                n_angle  = cftp_pkg::ANG_NONE;
            end
            n_snap.valid = n_snap.cap || n_snap.eom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_found  <= '0;
            r_oop    <= 1'b0;
            r_digits <= '0;
            r_points <= '0;
            r_m      <= '0;
            r_q      <= '0;
            r_k      <= '0;
            r_infrac <= 1'b0;
            r_info   <= cftp_pkg::INFO_NONE;
            r_angle  <= cftp_pkg::ANG_NONE;
            r_snap   <= '0;
        end else begin
            r_pos    <= n_pos;
            r_found  <= n_found;
            r_oop    <= n_oop;
            r_digits <= n_digits;
            r_points <= n_points;
            r_m      <= n_m;
            r_q      <= n_q;
            r_k      <= n_k;
            r_infrac <= n_infrac;
            r_info   <= n_info;
            r_angle  <= n_angle;
            if (i_load) begin
                r_snap <= n_snap;
            end
        end
    end

    assign o_snap = r_snap;

endmodule

`default_nettype wire

>>> rtl/control_frame_text_parser.sv
// Command frame text parser, top level.
// Depends on cftp_pkg, cftp_ifs (channel interfaces) and cftp_scan.
`default_nettype none

// Takes a 48-character command frame ($/# V volt A D/R angle ; P kp I ki D kd !)
// one character per cycle while i_chr.ready is high and, for the character flagged
// end_of_message, returns one result on o_res: a status (good, wrong length,
// character out of place, incomplete), the frame and angle type codes, and the
// five fields as unsigned fixed point scaled by 10^7. Characters that do not end
// a frame give no result. The digit shift-add and position decode in the scanner
// are combinational. The result passes through the snapshot register, then the
// 27x24 scaling multiplier, into the result register.
// i_chr.ready drops only when a frame end sits in the snapshot register while
// the previous result is still waiting in the output register.
module control_frame_text_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cftp_in_if.sink    i_chr,
    cftp_out_if.source o_res
);

    cftp_pkg::t_snap snap;

    logic out_free;     // output register can take a new result this cycle
    logic snap_go;      // snapshot stage retires this cycle
    logic slot_free;    // snapshot stage can take a new entry
    logic take;

    logic [cftp_pkg::SCALE_W-1:0]          scale;
    logic [cftp_pkg::VAL_W-1:0]            prod;
    logic [cftp_pkg::VAL_W-1:0]            value;
    logic                                  keep_vals;

    // held field values of the frame in progress
    logic [cftp_pkg::VAL_W-1:0] r_volt_held;
    logic [cftp_pkg::VAL_W-1:0] r_ang_held;
    logic [cftp_pkg::VAL_W-1:0] r_kp_held;
    logic [cftp_pkg::VAL_W-1:0] r_ki_held;

    // result register
    logic                       r_out_valid;
    cftp_pkg::t_status          r_status;
    cftp_pkg::t_info            r_info;
    cftp_pkg::t_angle           r_angle;
    logic [cftp_pkg::VAL_W-1:0] r_volt;
    logic [cftp_pkg::VAL_W-1:0] r_ang;
    logic [cftp_pkg::VAL_W-1:0] r_kp;
    logic [cftp_pkg::VAL_W-1:0] r_ki;
    logic [cftp_pkg::VAL_W-1:0] r_kd;

    // Only frame ends need the output register; field captures retire into
    // the held registers every cycle.
    assign out_free  = !r_out_valid || o_res.ready;
    assign snap_go   = snap.valid && (!snap.eom || out_free);
    assign slot_free = !snap.valid || snap_go;
    assign take      = i_chr.valid && slot_free;

    assign i_chr.ready = slot_free;

    cftp_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_load   (slot_free),
        .i_symbol (i_chr.symbol),
        .i_eom    (i_chr.end_of_message),
        .o_snap   (snap)
    );

    // Field value: m * 10^(7-k) for up to seven fraction digits, otherwise the
    // pre-scaled quotient tracked by the scanner. Max 99999999 * 10^7 < 2^50.
    assign scale = cftp_pkg::scale_of(snap.k);
    assign prod  = {23'b0, snap.m} * {26'b0, scale};
    assign value = (snap.k > 4'd7) ? {23'b0, snap.q} : prod;

    // wrong length or misplaced character zeroes everything but the status
    assign keep_vals = (snap.status == cftp_pkg::ST_GOOD) ||
                       (snap.status == cftp_pkg::ST_INCOMPLETE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_volt_held <= '0;
            r_ang_held  <= '0;
            r_kp_held   <= '0;
            r_ki_held   <= '0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (snap_go) begin
                if (snap.eom) begin
                    r_out_valid <= 1'b1;
                    r_volt_held <= '0;
                    r_ang_held  <= '0;
                    r_kp_held   <= '0;
                    r_ki_held   <= '0;
                end else if (snap.cap) begin
                    case (snap.sel)
                        cftp_pkg::FLD_VOLT:  r_volt_held <= value;
                        cftp_pkg::FLD_ANGLE: r_ang_held  <= value;
                        cftp_pkg::FLD_KP:    r_kp_held   <= value;
                        cftp_pkg::FLD_KI:    r_ki_held   <= value;
                        default:             r_ki_held   <= r_ki_held;
                    endcase
                end
            end
        end
    end

    // result payload, loaded with the frame end
    always_ff @(posedge i_clk) begin
        if (snap_go && snap.eom) begin
            r_status <= snap.status;
            if (keep_vals) begin
                r_info  <= snap.info;
                r_angle <= snap.angle;
                r_volt  <= r_volt_held;
                r_ang   <= r_ang_held;
                r_kp    <= r_kp_held;
                r_ki    <= r_ki_held;
                r_kd    <= (snap.cap && snap.sel == cftp_pkg::FLD_KD) ? value : '0;
            end else begin
                r_info  <= cftp_pkg::INFO_NONE;
                r_angle <= cftp_pkg::ANG_NONE;
                r_volt  <= '0;
                r_ang   <= '0;
                r_kp    <= '0;
                r_ki    <= '0;
                r_kd    <= '0;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_status;
    assign o_res.info_type  = r_info;
    assign o_res.angle_type = r_angle;
    assign o_res.voltage    = r_volt;
    assign o_res.angle      = r_ang;
    assign o_res.kp         = r_kp;
    assign o_res.ki         = r_ki;
    assign o_res.kd         = r_kd;

    // a good frame always carries both type markers
    a_good_types : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == cftp_pkg::ST_GOOD |->
            r_info != cftp_pkg::INFO_NONE && r_angle != cftp_pkg::ANG_NONE)
        else $error("good frame without type codes");

    // rejected frames report nothing but the status
    a_reject_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == cftp_pkg::ST_LENGTH || r_status == cftp_pkg::ST_PLACE) |->
            r_volt == '0 && r_ang == '0 && r_kp == '0 && r_ki == '0 && r_kd == '0 &&
            r_info == cftp_pkg::INFO_NONE)
        else $error("rejected frame carries values");

    // scaled quotient must equal the mantissa until the eighth fraction digit
    a_quot_track : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap.valid && snap.cap && snap.k <= 4'd7 |-> snap.q == snap.m)
        else $error("quotient tracker out of step with mantissa");

endmodule

`default_nettype wire

>>> verif/tb_control_frame_text_parser.sv
// Self-checking testbench for control_frame_text_parser: directed and random command frames.
// Depends on cftp_pkg (codes, character and position constants) and cftp_ifs (channels).

typedef struct {
    cftp_pkg::t_status          status;
    cftp_pkg::t_info            info;
    cftp_pkg::t_angle           ang;
    logic [cftp_pkg::VAL_W-1:0] voltage;
    logic [cftp_pkg::VAL_W-1:0] angle;
    logic [cftp_pkg::VAL_W-1:0] kp;
    logic [cftp_pkg::VAL_W-1:0] ki;
    logic [cftp_pkg::VAL_W-1:0] kd;
} t_frame_result;

// Frame parser model plus the queue of frame results still owed by the block.
class frame_scoreboard;
    t_frame_result              owed[$];
    int                         errors;
    int                         n_checked;
    logic [5:0]                 pos;
    logic [8:0]                 marks;
    bit                         misplaced;
    int unsigned                n_digits;
    int unsigned                n_points;
    longint unsigned            mant;
    int unsigned                n_frac;
    bit                         in_frac;
    cftp_pkg::t_info            kind;
    cftp_pkg::t_angle           akind;
    logic [cftp_pkg::VAL_W-1:0] volt_h;
    logic [cftp_pkg::VAL_W-1:0] ang_h;
    logic [cftp_pkg::VAL_W-1:0] kp_h;
    logic [cftp_pkg::VAL_W-1:0] ki_h;

    function new();
        errors    = 0;
        n_checked = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        pos       = '0;
        marks     = '0;
        misplaced = 0;
        n_digits  = 0;
        n_points  = 0;
        mant      = 0;
        n_frac    = 0;
        in_frac   = 0;
        kind      = cftp_pkg::INFO_NONE;
        akind     = cftp_pkg::ANG_NONE;
        volt_h    = '0;
        ang_h     = '0;
        kp_h      = '0;
        ki_h      = '0;
    endfunction

    function longint unsigned ten_pow(int n);
        longint unsigned r;
        r = 1;
        repeat (n) r = r * 10;
        return r;
    endfunction

    // scaled value of the field being read, then start a fresh field
    function logic [cftp_pkg::VAL_W-1:0] close_field();
        longint unsigned v;
        if (n_frac <= 7) v = mant * ten_pow(7 - n_frac);
        else             v = mant / ten_pow(n_frac - 7);
        mant    = 0;
        n_frac  = 0;
        in_frac = 0;
        return v[cftp_pkg::VAL_W-1:0];
    endfunction

    // 1 when c is the marker that belongs at p; applies it
    function bit take_marker(logic [5:0] p, logic [7:0] c,
                             output logic [cftp_pkg::VAL_W-1:0] kd);
        kd = '0;
        case (p)
            cftp_pkg::POS_HEAD: begin
                if (c == cftp_pkg::CH_DOLLAR)    kind = cftp_pkg::INFO_MOTOR;
                else if (c == cftp_pkg::CH_HASH) kind = cftp_pkg::INFO_FEEDBACK;
                else return 0;
                marks[0] = 1'b1;
                return 1;
            end
            cftp_pkg::POS_V: begin
                if (c != cftp_pkg::CH_V) return 0;
                marks[1] = 1'b1;
                return 1;
            end
            cftp_pkg::POS_A: begin
                if (c != cftp_pkg::CH_A) return 0;
                marks[2] = 1'b1;
                volt_h = close_field();
                return 1;
            end
            cftp_pkg::POS_ANG: begin
                if (c == cftp_pkg::CH_D)      akind = cftp_pkg::ANG_DEG;
                else if (c == cftp_pkg::CH_R) akind = cftp_pkg::ANG_RAD;
                else return 0;
                marks[3] = 1'b1;
                return 1;
            end
            cftp_pkg::POS_SEMI: begin
                if (c != cftp_pkg::CH_SEMI) return 0;
                marks[4] = 1'b1;
                ang_h = close_field();
                return 1;
            end
            cftp_pkg::POS_P: begin
                if (c != cftp_pkg::CH_P) return 0;
                marks[5] = 1'b1;
                return 1;
            end
            cftp_pkg::POS_I: begin
                if (c != cftp_pkg::CH_I) return 0;
                marks[6] = 1'b1;
                kp_h = close_field();
                return 1;
            end
            cftp_pkg::POS_D: begin
                if (c != cftp_pkg::CH_D) return 0;
                marks[7] = 1'b1;
                ki_h = close_field();
                return 1;
            end
            cftp_pkg::POS_BANG: begin
                if (c != cftp_pkg::CH_BANG) return 0;
                marks[8] = 1'b1;
                kd = close_field();
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    // one accepted character; queues a result when it closes the frame
    function void note_char(logic [7:0] c, logic last);
        logic [5:0]                 p;
        logic [cftp_pkg::VAL_W-1:0] kd_val;
        longint unsigned            nxt;
        t_frame_result              r;
        p      = pos;
        kd_val = '0;
        if (p < cftp_pkg::FRAME_LEN && !misplaced) begin
            if (!take_marker(p, c, kd_val)) begin
                if (c >= cftp_pkg::CH_ZERO && c <= cftp_pkg::CH_NINE) begin
                    nxt  = mant * 10 + (c - cftp_pkg::CH_ZERO);
                    mant = (mant > cftp_pkg::MANT_TENTH || nxt > cftp_pkg::MANT_MAX) ?
                           cftp_pkg::MANT_MAX : nxt;
                    if (in_frac && n_frac < 15) n_frac++;
                    if (n_digits < 63) n_digits++;
                end else if (c == cftp_pkg::CH_POINT) begin
                    in_frac = 1;
                    if (n_points < 63) n_points++;
                end else begin
                    misplaced = 1;
                end
            end
        end
        if (pos < 63) pos++;
        if (!last) return;

        r.info    = cftp_pkg::INFO_NONE;
        r.ang     = cftp_pkg::ANG_NONE;
        r.voltage = '0;
        r.angle   = '0;
        r.kp      = '0;
        r.ki      = '0;
        r.kd      = '0;
        if (int'(p) + 1 != cftp_pkg::FRAME_LEN)
            r.status = cftp_pkg::ST_LENGTH;
        else if (misplaced)
            r.status = cftp_pkg::ST_PLACE;
        else if (n_digits == cftp_pkg::DIGITS_NEEDED && n_points == cftp_pkg::POINTS_NEEDED
                 && &marks)
            r.status = cftp_pkg::ST_GOOD;
        else
            r.status = cftp_pkg::ST_INCOMPLETE;
        if (r.status == cftp_pkg::ST_GOOD || r.status == cftp_pkg::ST_INCOMPLETE) begin
            r.info    = kind;
            r.ang     = akind;
            r.voltage = volt_h;
            r.angle   = ang_h;
            r.kp      = kp_h;
            r.ki      = ki_h;
            r.kd      = kd_val;
        end
        owed.push_back(r);
        clear_frame();
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
        $display("result %0d: %s got %0d expected %0d", n_checked, what, got, want);
        errors++;
    endtask

    task check_result(t_frame_result got);
        t_frame_result want;
        n_checked++;
        if (owed.size() == 0) begin
            report("unexpected result, status", got.status, 0);
            return;
        end
        want = owed.pop_front();
        if (got.status  != want.status)  report("status", got.status, want.status);
        if (got.info    != want.info)    report("info_type", got.info, want.info);
        if (got.ang     != want.ang)     report("angle_type", got.ang, want.ang);
        if (got.voltage != want.voltage) report("voltage", got.voltage, want.voltage);
        if (got.angle   != want.angle)   report("angle", got.angle, want.angle);
        if (got.kp      != want.kp)      report("kp", got.kp, want.kp);
        if (got.ki      != want.ki)      report("ki", got.ki, want.ki);
        if (got.kd      != want.kd)      report("kd", got.kd, want.kd);
    endtask
endclass

module tb_control_frame_text_parser;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound on the run length
    localparam int CYCLE_LIMIT  = 400000;
    // drain time after the last result is due, with margin
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_CHARS = 480;
    localparam int MAX_GAP      = 20;

    // where the five decimal points go in a well-formed frame
    typedef enum int {
        PT_PER_FIELD,   // one at a random slot of each field
        PT_ANYWHERE,    // five at random numeric slots
        PT_FIELD_HEAD,  // first slot of each field
        PT_FIELD_TAIL   // last slot of each field
    } t_point_mode;

    typedef enum int {
        DIG_RANDOM,
        DIG_NINES,
        DIG_ZEROS
    } t_digit_style;

    logic            clk;
    logic            rst_n;
    int unsigned     cycles = 0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              hold_left = 0;
    int unsigned     chars_sent;
    int unsigned     frames_sent;
    logic [7:0]      frame_buf[$];
    frame_scoreboard sb = new();

    cftp_in_if  chr_if();
    cftp_out_if res_if();

    control_frame_text_parser uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_chr   (chr_if),
        .o_res   (res_if)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_control_frame_text_parser: errors");
            $finish;
        end
    end

    // Both handshakes are sampled here, right after the edge, so the values seen are the
    // ones the block saw. The same process drives the result ready: a long hold-off
    // requested by the stimulus is counted down here, otherwise ready idles at random.
    always @(posedge clk) begin : watch
        t_frame_result got;
        if (rst_n) begin
            if (chr_if.valid && chr_if.ready)
                sb.note_char(chr_if.symbol, chr_if.end_of_message);
            if (res_if.valid && res_if.ready) begin
                got.status  = res_if.status;
                got.info    = res_if.info_type;
                got.ang     = res_if.angle_type;
                got.voltage = res_if.voltage;
                got.angle   = res_if.angle;
                got.kp      = res_if.kp;
                got.ki      = res_if.ki;
                got.kd      = res_if.kd;
                sb.check_result(got);
            end
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic bit is_mark_pos(int p);
        case (p)
            cftp_pkg::POS_HEAD, cftp_pkg::POS_V, cftp_pkg::POS_A, cftp_pkg::POS_ANG,
            cftp_pkg::POS_SEMI, cftp_pkg::POS_P, cftp_pkg::POS_I, cftp_pkg::POS_D,
            cftp_pkg::POS_BANG: return 1;
            default:            return 0;
        endcase
    endfunction

    // numeric fields: voltage, angle, kp, ki, kd
    function automatic int field_start(int f);
        case (f)
            0:       return cftp_pkg::POS_V + 1;
            1:       return cftp_pkg::POS_ANG + 1;
            2:       return cftp_pkg::POS_P + 1;
            3:       return cftp_pkg::POS_I + 1;
            default: return cftp_pkg::POS_D + 1;
        endcase
    endfunction

    function automatic int field_len(int f);
        return (f == 0) ? 7 : 8;
    endfunction

    // Fill frame_buf with a 48-character frame that parses clean.
    task automatic build_good(input logic [7:0] head, input logic [7:0] ang,
                              input t_point_mode pmode, input t_digit_style style);
        bit pt[48];
        int placed;
        int p;
        frame_buf.delete();
        for (p = 0; p < 48; p++) pt[p] = 0;
        case (pmode)
            PT_PER_FIELD:
                for (int f = 0; f < 5; f++)
                    pt[field_start(f) + $urandom_range(field_len(f) - 1)] = 1;
            PT_ANYWHERE: begin
                placed = 0;
                while (placed < cftp_pkg::POINTS_NEEDED) begin
                    p = $urandom_range(47);
                    if (!is_mark_pos(p) && !pt[p]) begin
                        pt[p] = 1;
                        placed++;
                    end
                end
            end
            PT_FIELD_HEAD:
                for (int f = 0; f < 5; f++) pt[field_start(f)] = 1;
            default:
                for (int f = 0; f < 5; f++) pt[field_start(f) + field_len(f) - 1] = 1;
        endcase
        for (p = 0; p < 48; p++) begin
            case (p)
                cftp_pkg::POS_HEAD: frame_buf.push_back(head);
                cftp_pkg::POS_V:    frame_buf.push_back(cftp_pkg::CH_V);
                cftp_pkg::POS_A:    frame_buf.push_back(cftp_pkg::CH_A);
                cftp_pkg::POS_ANG:  frame_buf.push_back(ang);
                cftp_pkg::POS_SEMI: frame_buf.push_back(cftp_pkg::CH_SEMI);
                cftp_pkg::POS_P:    frame_buf.push_back(cftp_pkg::CH_P);
                cftp_pkg::POS_I:    frame_buf.push_back(cftp_pkg::CH_I);
                cftp_pkg::POS_D:    frame_buf.push_back(cftp_pkg::CH_D);
                cftp_pkg::POS_BANG: frame_buf.push_back(cftp_pkg::CH_BANG);
                default: begin
                    if (pt[p])                   frame_buf.push_back(cftp_pkg::CH_POINT);
                    else if (style == DIG_NINES) frame_buf.push_back(cftp_pkg::CH_NINE);
                    else if (style == DIG_ZEROS) frame_buf.push_back(cftp_pkg::CH_ZERO);
                    else frame_buf.push_back(8'(cftp_pkg::CH_ZERO + $urandom_range(9)));
                end
            endcase
        end
    endtask

    // Clean frames with random content in 45 percent of cases; the rest broken in one way or another.
    task automatic random_frame();
        int r;
        int p;
        build_good($urandom_range(1) ? cftp_pkg::CH_DOLLAR : cftp_pkg::CH_HASH,
                   $urandom_range(1) ? cftp_pkg::CH_D : cftp_pkg::CH_R,
                   t_point_mode'($urandom_range(3)),
                   ($urandom_range(9) == 0) ? DIG_NINES : DIG_RANDOM);
        r = $urandom_range(99);
        if (r < 45) begin
            // left clean
        end else if (r < 52) begin
            // marker replaced by any character
            do p = $urandom_range(47); while (!is_mark_pos(p));
            frame_buf[p] = 8'($urandom_range(1, 255));
        end else if (r < 60) begin
            // numeric slot replaced by any character
            do p = $urandom_range(47); while (is_mark_pos(p));
            frame_buf[p] = 8'($urandom_range(1, 255));
        end else if (r < 67) begin
            // digit where a marker belongs: field runs on into the next one
            do p = $urandom_range(47); while (!is_mark_pos(p));
            frame_buf[p] = 8'(cftp_pkg::CH_ZERO + $urandom_range(9));
        end else if (r < 74) begin
            // digit/point count off by one
            do p = $urandom_range(47); while (is_mark_pos(p));
            frame_buf[p] = (frame_buf[p] == cftp_pkg::CH_POINT) ?
                           8'(cftp_pkg::CH_ZERO + $urandom_range(9)) : cftp_pkg::CH_POINT;
        end else if (r < 80) begin
            p = $urandom_range(1, 47);
            while (frame_buf.size() > p) frame_buf.delete(frame_buf.size() - 1);
        end else if (r < 85) begin
            repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom_range(1, 255)));
        end else if (r < 92) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 64)) frame_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            // closing markers turned to digits: mantissa and fraction count saturate
            frame_buf[cftp_pkg::POS_A]    = cftp_pkg::CH_NINE;
            frame_buf[cftp_pkg::POS_SEMI] = cftp_pkg::CH_NINE;
            frame_buf[cftp_pkg::POS_I]    = 8'(cftp_pkg::CH_ZERO + $urandom_range(9));
            frame_buf[cftp_pkg::POS_D]    = cftp_pkg::CH_NINE;
        end
    endtask

    // Offer one character; valid is only dropped when a gap is taken, so back-to-back
    // items never see valid lowered and raised in the same step.
    task automatic send_char(input logic [7:0] sym, input logic last);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            chr_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chr_if.valid          <= 1'b1;
        chr_if.symbol         <= sym;
        chr_if.end_of_message <= last;
        @(posedge clk);
        while (!chr_if.ready) @(posedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_char(frame_buf[i], i == frame_buf.size() - 1);
        chars_sent  += frame_buf.size();
        frames_sent++;
    endtask

    // Sender pause until every owed result is back. The first edge lets the watcher
    // take in the character accepted on the edge we returned on.
    task automatic wait_results();
        chr_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
    endtask

    initial begin
        chr_if.valid          = 1'b0;
        chr_if.symbol         = cftp_pkg::CH_ZERO;
        chr_if.end_of_message = 1'b0;
        res_if.ready          = 1'b0;
        rst_n                 = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 51;

        // ---- directed frames ----
        // clean frames: extremes of digits and point placement, both types of each
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_D, PT_PER_FIELD, DIG_NINES);
        send_frame();
        build_good(cftp_pkg::CH_HASH, cftp_pkg::CH_R, PT_PER_FIELD, DIG_ZEROS);
        send_frame();
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_R, PT_FIELD_HEAD, DIG_NINES);
        send_frame();
        build_good(cftp_pkg::CH_HASH, cftp_pkg::CH_D, PT_FIELD_TAIL, DIG_NINES);
        send_frame();
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_D, PT_ANYWHERE, DIG_RANDOM);
        send_frame();
        // digit in place of the A marker: voltage never stored, angle absorbs it
        build_good(cftp_pkg::CH_HASH, cftp_pkg::CH_D, PT_PER_FIELD, DIG_RANDOM);
        frame_buf[cftp_pkg::POS_A] = 8'(cftp_pkg::CH_ZERO + 5);
        send_frame();
        // R is the angle type only at its own slot, not as the Kd marker
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_R, PT_PER_FIELD, DIG_RANDOM);
        frame_buf[cftp_pkg::POS_D] = cftp_pkg::CH_R;
        send_frame();
        // frame marker inside the voltage field
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_D, PT_PER_FIELD, DIG_RANDOM);
        frame_buf[5] = cftp_pkg::CH_DOLLAR;
        send_frame();
        // bad leading character, high bit set
        build_good(cftp_pkg::CH_HASH, cftp_pkg::CH_R, PT_PER_FIELD, DIG_RANDOM);
        frame_buf[cftp_pkg::POS_HEAD] = 8'hFF;
        send_frame();
        // no closing bang: kd stays zero, point count one too high
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_D, PT_PER_FIELD, DIG_RANDOM);
        frame_buf[cftp_pkg::POS_BANG] = cftp_pkg::CH_POINT;
        send_frame();
        // one extra point in kp
        build_good(cftp_pkg::CH_HASH, cftp_pkg::CH_D, PT_FIELD_HEAD, DIG_RANDOM);
        frame_buf[field_start(2) + 1] = cftp_pkg::CH_POINT;
        send_frame();
        // one short, one long, a single character, and far past the position limit
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_D, PT_PER_FIELD, DIG_RANDOM);
        frame_buf.delete(frame_buf.size() - 1);
        send_frame();
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_D, PT_PER_FIELD, DIG_RANDOM);
        frame_buf.push_back(cftp_pkg::CH_ZERO);
        send_frame();
        frame_buf.delete();
        frame_buf.push_back(cftp_pkg::CH_DOLLAR);
        send_frame();
        build_good(cftp_pkg::CH_HASH, cftp_pkg::CH_R, PT_PER_FIELD, DIG_RANDOM);
        repeat (22) frame_buf.push_back(cftp_pkg::CH_NINE);
        send_frame();
        // closing markers as nines: mantissa saturation, more than seven fraction digits
        build_good(cftp_pkg::CH_DOLLAR, cftp_pkg::CH_D, PT_FIELD_HEAD, DIG_NINES);
        frame_buf[cftp_pkg::POS_A]    = cftp_pkg::CH_NINE;
        frame_buf[cftp_pkg::POS_SEMI] = cftp_pkg::CH_NINE;
        frame_buf[cftp_pkg::POS_I]    = cftp_pkg::CH_NINE;
        frame_buf[cftp_pkg::POS_D]    = cftp_pkg::CH_NINE;
        send_frame();
        // right length, random nonzero characters
        frame_buf.delete();
        repeat (cftp_pkg::FRAME_LEN) frame_buf.push_back(8'($urandom_range(1, 255)));
        send_frame();
        wait_results();

        // ---- random frames in three idling phases ----
        chars_sent  = 0;
        frames_sent = 0;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 22; recv_idle_pct = 51; end
                1:       begin send_idle_pct = 51; recv_idle_pct = 22; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            while (chars_sent < RANDOM_CHARS * (ph + 1) / 3 || frames_sent < 3 * (ph + 1))
            begin
                random_frame();
                send_frame();
            end
            if (ph == 0) begin
                // Receiver holds off while a burst of tiny frames piles up frame ends,
                // so the block backs up and drops its input ready.
                send_idle_pct = 0;
                hold_left     = 400;
                repeat (24) begin
                    frame_buf.delete();
                    repeat ($urandom_range(1, 3))
                        frame_buf.push_back(8'($urandom_range(1, 255)));
                    send_frame();
                end
            end
            wait_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.owed.size() != 0) sb.report("results never seen, count", 0, sb.owed.size());
        if (sb.errors == 0)
            $display("tb_control_frame_text_parser: clean");
        else
            $display("tb_control_frame_text_parser: errors");
        $finish;
    end

endmodule
